// ===== sv/assert_macros.svh =====
// Assertion macros shared by the find-and-replace RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define SFR_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SFR_NEVER(label, clk, rst_n, cond, msg) \
	`SFR_ASSERT(label, clk, rst_n, !(cond), msg)

`endif

// ===== sv/sfr_pkg.sv =====
// Shared types and constants of the stream find-and-replace block.
`default_nettype none
package sfr_pkg;

	localparam int PATTERN_MAX = 8;
	localparam int REPLACE_MAX = 8;
	localparam int JOB_MAX = (PATTERN_MAX > REPLACE_MAX) ? PATTERN_MAX : REPLACE_MAX;
	localparam int LEN_W = 4;
	localparam int IDX_W = $clog2(JOB_MAX);
	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_BYTES     = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH    = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_BYTES = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_REPLACEMENT_LENGTH = 2'd3;

	// One queued emission job: bytes to send, how many, and end of stream.
	typedef struct packed {
		logic [JOB_MAX-1:0][7:0] bytes;
		logic [LEN_W-1:0]        cnt;
		logic                    fin;
	} job_t;

endpackage
`default_nettype wire

// ===== sv/sfr_front.sv =====
// Front end: configuration registers, match window and job classification.
`default_nettype none
`include "assert_macros.svh"
module sfr_front (
	input  wire                         clk,
	input  wire                         arst_n,
	input  wire                         cfg_we,
	input  wire [sfr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  wire [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                         s_tvalid,
	output logic                        s_tready,
	input  wire [7:0]                   s_tdata,   // in_byte
	input  wire                         s_tlast,   // final_byte
	input  wire                         q_full,
	output logic                        push,
	output sfr_pkg::job_t               job
);
	import sfr_pkg::*;

	logic [CFG_DATA_W-1:0]       pat_q;
	logic [LEN_W-1:0]            pat_len_q;
	logic [CFG_DATA_W-1:0]       rep_q;
	logic [LEN_W-1:0]            rep_len_q;
	logic [PATTERN_MAX-1:0][7:0] win_q;
	logic [LEN_W-1:0]            win_cnt_q;

	logic [LEN_W-1:0]            plen, rlen, wc0, wc1, k, cnt_d;
	logic [PATTERN_MAX-1:0][7:0] w, sh;
	logic                        eq_all, match, accept;

	always_comb begin
		if (pat_len_q == '0) begin
			plen = LEN_W'(1);
		end else if (pat_len_q > LEN_W'(PATTERN_MAX)) begin
			plen = LEN_W'(PATTERN_MAX);
		end else begin
			plen = pat_len_q;
		end
		rlen = (rep_len_q > LEN_W'(REPLACE_MAX)) ? LEN_W'(REPLACE_MAX) : rep_len_q;
		wc0 = (win_cnt_q >= LEN_W'(PATTERN_MAX)) ? LEN_W'(PATTERN_MAX - 1) : win_cnt_q;
		wc1 = wc0 + LEN_W'(1);
		eq_all = 1'b1;
		for (int i = 0; i < PATTERN_MAX; i++) begin
			w[i] = (LEN_W'(i) == wc0) ? s_tdata : win_q[i];
			if (LEN_W'(i) < plen && w[i] != pat_q[i*8 +: 8]) begin
				eq_all = 1'b0;
			end
		end
		match = (wc1 == plen) && eq_all;
		if (wc1 > plen) begin
			k = s_tlast ? wc1 : wc1 - plen + LEN_W'(1);
		end else if (match) begin
			k = '0;
		end else if (wc1 == plen && !s_tlast) begin
			k = LEN_W'(1);
		end else begin
			k = s_tlast ? wc1 : '0;
		end
		for (int i = 0; i < PATTERN_MAX; i++) begin
			sh[i] = 8'h00;
			for (int j = 0; j < PATTERN_MAX; j++) begin
				if (LEN_W'(j) == LEN_W'(i) + k) begin
					sh[i] = w[j];
				end
			end
		end
		cnt_d = (match || s_tlast) ? '0 : wc1 - k;
		job.bytes = match ? rep_q : w;
		job.cnt = match ? rlen : k;
		job.fin = s_tlast;
	end

	assign s_tready = !q_full;
	assign accept = s_tvalid && s_tready;
	assign push = accept && (job.cnt != '0 || s_tlast);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pat_q <= '0;
			pat_len_q <= LEN_W'(1);
			rep_q <= '0;
			rep_len_q <= '0;
			win_cnt_q <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_PATTERN_BYTES:      pat_q <= cfg_data;
					REG_PATTERN_LENGTH:     pat_len_q <= cfg_data[LEN_W-1:0];
					REG_REPLACEMENT_BYTES:  rep_q <= cfg_data;
					REG_REPLACEMENT_LENGTH: rep_len_q <= cfg_data[LEN_W-1:0];
					default: ;
				endcase
			end
			if (accept) begin
				win_cnt_q <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			win_q <= sh;
		end
	end

	`SFR_ASSERT(a_win_bound, clk, arst_n, win_cnt_q < LEN_W'(PATTERN_MAX), "window overfull")
	`SFR_ASSERT(a_job_bound, clk, arst_n, push |-> job.cnt <= LEN_W'(JOB_MAX), "job too long")

endmodule
`default_nettype wire

// ===== sv/sfr_queue.sv =====
// Job queue between front end and back end.
`default_nettype none
`include "assert_macros.svh"
module sfr_queue (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                push,
	input  wire sfr_pkg::job_t push_job,
	output logic               full,
	input  wire                pop,
	output logic               head_valid,
	output sfr_pkg::job_t      head
);
	import sfr_pkg::*;

	job_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [QCNT_W-1:0] cnt_q;

	assign full = (cnt_q == QCNT_W'(QUEUE_DEPTH));
	assign head_valid = (cnt_q != '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	`SFR_NEVER(a_no_overflow, clk, arst_n, push && full, "push into full queue")
	`SFR_NEVER(a_no_underflow, clk, arst_n, pop && !head_valid, "pop from empty queue")

endmodule
`default_nettype wire

// ===== sv/sfr_back.sv =====
// Back end: expands queued jobs into output bytes through an output register.
`default_nettype none
`include "assert_macros.svh"
module sfr_back (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                head_valid,
	input  wire sfr_pkg::job_t head,
	output logic               pop,
	output logic               m_tvalid,
	input  wire                m_tready,
	output logic [7:0]         m_tdata,   // out_byte
	output logic               m_tlast,   // run_last
	output logic [1:0]         m_tuser    // [0] byte_valid, [1] stream_end
);
	import sfr_pkg::*;

	logic [IDX_W-1:0] idx_q;
	logic             vld_q, last_q, bv_q, se_q;
	logic [7:0]       data_q;
	logic             load, last;

	assign load = !vld_q || m_tready;
	assign last = (head.cnt == '0) || (LEN_W'(idx_q) + LEN_W'(1) == head.cnt);
	assign pop = load && head_valid && last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
			idx_q <= '0;
		end else if (load) begin
			vld_q <= head_valid;
			if (head_valid) begin
				idx_q <= last ? '0 : idx_q + IDX_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load && head_valid) begin
			data_q <= (head.cnt == '0) ? 8'h00 : head.bytes[idx_q];
			bv_q <= (head.cnt != '0);
			last_q <= last;
			se_q <= last && head.fin;
		end
	end

	assign m_tvalid = vld_q;
	assign m_tdata = data_q;
	assign m_tlast = last_q;
	assign m_tuser = {se_q, bv_q};

	`SFR_ASSERT(a_end_is_last, clk, arst_n, vld_q && se_q |-> last_q, "stream end not last")
	`SFR_ASSERT(a_idx_in_job, clk, arst_n,
		head_valid && head.cnt != '0 |-> LEN_W'(idx_q) < head.cnt, "index past job")

endmodule
`default_nettype wire

// ===== sv/stream_find_replace_core.sv =====
// Accepted items are queued as jobs; results then pass through the output register.
// Throughput: one input byte per cycle while each byte yields at most one result and
// m_tready is high; a byte with n results sends them in turn, a 4-job queue absorbs bursts.
// The output register sends one result per ready cycle; bytes held in the window give none.
// Reset (arst_n low, asynchronous): window empty, queue empty, output idle,
// pattern 0 of length 1, replacement empty.
`default_nettype none
module stream_find_replace_core (
	input  wire                           clk,
	input  wire                           arst_n,
	input  wire                           cfg_we,
	input  wire [sfr_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire [sfr_pkg::CFG_DATA_W-1:0] cfg_data,
	input  wire                           s_tvalid,
	output logic                          s_tready,
	input  wire [7:0]                     s_tdata,   // in_byte
	input  wire                           s_tlast,   // final_byte
	output logic                          m_tvalid,
	input  wire                           m_tready,
	output logic [7:0]                    m_tdata,   // out_byte
	output logic                          m_tlast,   // run_last
	output logic [1:0]                    m_tuser    // [0] byte_valid, [1] stream_end
);
	import sfr_pkg::*;

	job_t push_job, head;
	logic push, full, pop, head_valid;

	sfr_front u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.q_full(full), .push(push), .job(push_job)
	);

	sfr_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_job(push_job), .full(full),
		.pop(pop), .head_valid(head_valid), .head(head)
	);

	sfr_back u_back (
		.clk(clk), .arst_n(arst_n),
		.head_valid(head_valid), .head(head), .pop(pop),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.m_tlast(m_tlast), .m_tuser(m_tuser)
	);

endmodule
`default_nettype wire
